[sv/m3inv_pkg.sv]
// shared widths and types for the 3x3 matrix inverse
package m3inv_pkg;
  localparam int InWidth     = 16;
  localparam int OutWidth    = 32;
  localparam int ThreshWidth = 47;
  localparam int AdjWidth    = 2 * InWidth + 1;
  localparam int DetWidth    = 3 * InWidth + 2;
  localparam int MagWidth    = DetWidth - 1;
  localparam int DivShift    = 28;
  localparam int NumWidth    = AdjWidth - 1 + DivShift;
  localparam int QWidth      = NumWidth;
  localparam logic [ThreshWidth-1:0] ThreshReset = ThreshWidth'(68719);
  localparam logic [OutWidth-1:0] OneVal = OutWidth'(65536);

  typedef logic signed [InWidth-1:0]  elem_t;
  typedef logic signed [AdjWidth-1:0] adj_t;
  typedef logic signed [DetWidth-1:0] det_t;

  typedef struct packed {
    logic valid;
    logic singular;
    logic neg;
  } lane_ctl_t;
endpackage

[sv/m3inv_adj.sv]
// cofactor and determinant stages: five register stages
module m3inv_adj
  import m3inv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  elem_t                  a [9],
  input  logic [ThreshWidth-1:0] thresh,
  output logic                   out_valid,
  output adj_t                   adj_q [9],
  output logic [MagWidth-1:0]    det_mag,
  output logic                   det_neg,
  output logic                   singular
);
  // a is column-major: a[3*c + r]
  logic signed [2*InWidth-1:0] p1 [9], p2 [9];
  elem_t  a1 [9];
  elem_t  a2 [9];
  adj_t   adj1 [9];
  logic signed [DetWidth-2:0] t2 [3];
  adj_t   adj2 [9];
  adj_t   adj3 [9];
  det_t   det;
  logic   v1, v2, v3, v4, v5;
  logic [MagWidth-1:0] mag;

  always_ff @(posedge clk) begin
    if (adv) begin
      // adj[c*3+r] = cofactor of element (row c, col r)
      p1[0] <= a[4] * a[8]; p2[0] <= a[7] * a[5];
      p1[1] <= a[7] * a[2]; p2[1] <= a[1] * a[8];
      p1[2] <= a[1] * a[5]; p2[2] <= a[4] * a[2];
      p1[3] <= a[6] * a[5]; p2[3] <= a[3] * a[8];
      p1[4] <= a[0] * a[8]; p2[4] <= a[6] * a[2];
      p1[5] <= a[3] * a[2]; p2[5] <= a[0] * a[5];
      p1[6] <= a[3] * a[7]; p2[6] <= a[6] * a[4];
      p1[7] <= a[6] * a[1]; p2[7] <= a[0] * a[7];
      p1[8] <= a[0] * a[4]; p2[8] <= a[3] * a[1];
      a1 <= a;
      for (int i = 0; i < 9; i++) begin
        adj1[i] <= AdjWidth'(p1[i]) - AdjWidth'(p2[i]);
      end
      a2 <= a1;
      for (int i = 0; i < 3; i++) begin
        t2[i] <= a2[3*i] * adj1[i];
      end
      adj2 <= adj1;
      det  <= DetWidth'(t2[0]) + DetWidth'(t2[1]) + DetWidth'(t2[2]);
      adj3 <= adj2;
    end
  end

  assign mag = det[DetWidth-1] ? MagWidth'(-det) : MagWidth'(det);
  always_ff @(posedge clk) begin
    if (adv) begin
      adj_q    <= adj3;
      det_mag  <= mag;
      det_neg  <= det[DetWidth-1];
      singular <= ({{(MagWidth-ThreshWidth){1'b0}}, thresh} >= mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end
  assign out_valid = v5;
endmodule

[sv/m3inv_div.sv]
// pipelined restoring divider, one quotient bit per stage, with saturation
module m3inv_div
  import m3inv_pkg::*;
(
  input  logic                clk,
  input  logic                adv,
  input  adj_t                num,
  input  logic [MagWidth-1:0] den,
  input  logic                den_neg,
  output logic [OutWidth-1:0] q,
  output logic                sat
);
  localparam int RemW = MagWidth + 1;
  logic [NumWidth-1:0] nq  [NumWidth+1];
  logic [RemW-1:0]     rem [NumWidth+1];
  logic [MagWidth-1:0] dn  [NumWidth+1];
  logic                ng  [NumWidth+1];
  logic [AdjWidth-2:0] nmag;

  assign nmag = num[AdjWidth-1] ? (AdjWidth-1)'(-num) : (AdjWidth-1)'(num);
  assign nq[0]  = {nmag, {DivShift{1'b0}}};
  assign rem[0] = '0;
  assign dn[0]  = den;
  assign ng[0]  = num[AdjWidth-1] ^ den_neg;

  for (genvar s = 0; s < NumWidth; s++) begin : g_st
    logic [RemW-1:0] sh, df;
    assign sh = {rem[s][RemW-2:0], nq[s][NumWidth-1]};
    assign df = sh - {1'b0, dn[s]};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1] <= df[RemW-1] ? sh : df;
        nq[s+1]  <= {nq[s][NumWidth-2:0], ~df[RemW-1]};
        dn[s+1]  <= dn[s];
        ng[s+1]  <= ng[s];
      end
    end
  end

  logic [QWidth-1:0] qm;
  localparam logic [QWidth-1:0] MaxPos = QWidth'({1'b0, {(OutWidth-1){1'b1}}});
  assign qm = nq[NumWidth];
  always_comb begin
    sat = 1'b0;
    if (!ng[NumWidth]) begin
      if (qm > MaxPos) begin q = OutWidth'(MaxPos); sat = 1'b1; end
      else q = OutWidth'(qm);
    end else begin
      if (qm > MaxPos + 1'b1) begin q = OutWidth'(MaxPos + 1'b1) ; sat = 1'b1; q = -q; end
      else q = OutWidth'(-qm);
    end
  end
  logic unused_r; assign unused_r = ^rem[NumWidth];
endmodule

[sv/matrix3_inverse.sv]
// 3x3 matrix inverse by the adjugate, fully pipelined
// pipeline: 5 cofactor/determinant stages, 60 divider stages, 1 output stage
// throughput: one item per cycle; a stall freezes the whole pipeline
// reset (rst, synchronous) clears all valid bits and sets det_threshold to 68719
module matrix3_inverse
  import m3inv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ThreshWidth-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  elem_t e_c0_r0, e_c0_r1, e_c0_r2, e_c1_r0, e_c1_r1, e_c1_r2,
  input  elem_t e_c2_r0, e_c2_r1, e_c2_r2,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [OutWidth-1:0] inv_c0_r0, inv_c0_r1, inv_c0_r2,
  output logic signed [OutWidth-1:0] inv_c1_r0, inv_c1_r1, inv_c1_r2,
  output logic signed [OutWidth-1:0] inv_c2_r0, inv_c2_r1, inv_c2_r2,
  output logic singular,
  output logic saturated
);
  logic [ThreshWidth-1:0] det_threshold;
  logic adv, av;
  elem_t a [9];
  adj_t adj [9];
  logic [MagWidth-1:0] dmag;
  logic dneg, sing;
  logic [OutWidth-1:0] q [9];
  logic [8:0] sv;
  logic [NumWidth-1:0] pv, ps;
  logic [OutWidth-1:0] r [9];

  always_ff @(posedge clk) begin
    if (rst) det_threshold <= ThreshReset;
    else if (cfg_we) det_threshold <= cfg_wdata;
  end

  // whole pipeline moves unless the output holds an item that is stalled
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign a = '{e_c0_r0, e_c0_r1, e_c0_r2, e_c1_r0, e_c1_r1, e_c1_r2,
               e_c2_r0, e_c2_r1, e_c2_r2};

  m3inv_adj u_adj (
    .clk, .rst, .adv, .in_valid, .a, .thresh(det_threshold),
    .out_valid(av), .adj_q(adj), .det_mag(dmag), .det_neg(dneg), .singular(sing)
  );

  for (genvar i = 0; i < 9; i++) begin : g_div
    m3inv_div u_div (
      .clk, .adv, .num(adj[i]), .den(dmag), .den_neg(dneg), .q(q[i]), .sat(sv[i])
    );
  end

  // valid and singular flag ride alongside the divider stages
  always_ff @(posedge clk) begin
    if (rst) pv <= '0;
    else if (adv) pv <= {pv[NumWidth-2:0], av};
  end
  always_ff @(posedge clk) begin
    if (adv) ps <= {ps[NumWidth-2:0], sing};
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= pv[NumWidth-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      singular  <= ps[NumWidth-1];
      saturated <= !ps[NumWidth-1] && (|sv);
      for (int i = 0; i < 9; i++) begin
        if (ps[NumWidth-1]) r[i] <= (i % 4 == 0) ? OneVal : '0;
        else r[i] <= q[i];
      end
    end
  end
  assign {inv_c0_r0, inv_c0_r1, inv_c0_r2, inv_c1_r0, inv_c1_r1, inv_c1_r2,
          inv_c2_r0, inv_c2_r1, inv_c2_r2} =
         {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]};

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inv_c0_r0) && $stable(singular))
    else $error("result changed under stall");
  a_sing_nosat: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> !saturated)
    else $error("singular item flagged saturated");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
endmodule
